// ===== hw/rtl/frame_change_detector_macros.svh =====
// Assertion macros for the frame change detector.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FRAME_CHANGE_DETECTOR_MACROS_SVH
`define FRAME_CHANGE_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define FCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FCD_ASSERT_IMPL(lbl, ante, cons, msg)
`define FCD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/fcd_pkg.sv =====
`timescale 1ns / 1ps

package fcd_pkg;

  // command codes
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_CLIP  = 2'd1;
  localparam logic [1:0] CMD_RECT  = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  // register map, indexed by paddr[2]
  localparam int          CFG_ADDR_W   = 3;
  localparam logic        REG_ORIGIN_X = 1'b0;
  localparam logic        REG_ORIGIN_Y = 1'b1;

  // FNV-1a
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // bytes folded per command
  localparam int HASH_BYTES_CLIP = 17;
  localparam int HASH_BYTES_RECT = 21;
  localparam int HCNT_W          = $clog2(HASH_BYTES_RECT + 1);
  localparam int HBUF_W          = 8 * HASH_BYTES_RECT;

  // coordinate widths: stored 18 bits, edge sums in 19 bits
  localparam int CRD_W = 18;
  localparam int SUM_W = 19;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;
    logic [7:0]         color_red;
    logic [7:0]         color_green;
    logic [7:0]         color_blue;
    logic [7:0]         color_alpha;
    logic [14:0]        surface_width;
    logic [14:0]        surface_height;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        hashed;
    logic        redraw;
    logic [31:0] frame_hash;
  } out_item_t;

endpackage

// ===== hw/rtl/frame_change_detector.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    fcd_pkg::in_item_t
// out      output     out_valid/out_ready  fcd_pkg::out_item_t
// cfg      input      APB psel/penable     origin_x, origin_y
//
// An item passes through ST_EVAL and then ST_FIN; when it is folded into the
// hash (17 or 21 bytes, one byte per cycle through the single xor-multiply
// unit) it passes through ST_HASH between them, and ST_FIN holds it for as
// long as the previous result still waits in the result register.
// Synchronous active-low reset; no clearing pass is needed.
// A waiting result does not block the next item from being accepted, only
// from finishing.

`include "frame_change_detector_macros.svh"

module frame_change_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fcd_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fcd_pkg::out_item_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fcd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_HASH = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic signed [15:0]                origin_x_r, origin_y_r;
  logic [14:0]                       surf_w_r, surf_h_r, surf_w_nxt, surf_h_nxt;
  logic signed [fcd_pkg::CRD_W-1:0]  clip_x_r, clip_y_r, clip_x_nxt, clip_y_nxt;
  logic [15:0]                       clip_w_r, clip_h_r, clip_w_nxt, clip_h_nxt;
  logic [31:0]                       cur_r, cur_nxt, prev_r, prev_nxt;
  logic                              first_r, first_nxt;
  fcd_pkg::in_item_t                 item_r;
  logic signed [fcd_pkg::CRD_W-1:0]  x_r, y_r;
  logic                              acc_r, hsh_r, red_r, acc_nxt, hsh_nxt, red_nxt;
  logic [fcd_pkg::HBUF_W-1:0]        hbuf_r, hbuf_nxt;
  logic [fcd_pkg::HCNT_W-1:0]        hcnt_r, hcnt_nxt;
  logic                              out_valid_r;
  fcd_pkg::out_item_t                out_data_r;

  logic                              in_fire, out_load, cfg_wr;
  logic [31:0]                       mix, prod;

  // edge arithmetic
  logic signed [fcd_pkg::SUM_W-1:0]  xe, ye, xw, yh, sw, sh;
  logic signed [fcd_pkg::SUM_W-1:0]  x1, y1, x2, y2, dx, dy;
  logic signed [fcd_pkg::SUM_W-1:0]  cxe, cye, cxw, cyh, iw, ih;
  logic                              overlap;
  logic [31:0]                       wd_x, wd_y, wd_w, wd_h;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[2])
      fcd_pkg::REG_ORIGIN_X: prdata = {{16{origin_x_r[15]}}, origin_x_r};
      fcd_pkg::REG_ORIGIN_Y: prdata = {{16{origin_y_r[15]}}, origin_y_r};
      default:               prdata = '0;
    endcase
  end

  // shared hash unit: one byte per cycle
  assign mix  = cur_r ^ {24'd0, hbuf_r[7:0]};
  assign prod = mix * fcd_pkg::FNV_PRIME;

  // operands widened for edge sums
  always_comb begin
    xe  = {x_r[fcd_pkg::CRD_W-1], x_r};
    ye  = {y_r[fcd_pkg::CRD_W-1], y_r};
    xw  = xe + $signed({4'd0, item_r.rect_width});
    yh  = ye + $signed({4'd0, item_r.rect_height});
    sw  = $signed({4'd0, surf_w_r});
    sh  = $signed({4'd0, surf_h_r});
    cxe = {clip_x_r[fcd_pkg::CRD_W-1], clip_x_r};
    cye = {clip_y_r[fcd_pkg::CRD_W-1], clip_y_r};
    cxw = cxe + $signed({3'd0, clip_w_r});
    cyh = cye + $signed({3'd0, clip_h_r});
    // set clip: cut to the surface
    x1  = (xe < 0) ? '0 : xe;
    y1  = (ye < 0) ? '0 : ye;
    x2  = (xw < sw) ? xw : sw;
    y2  = (yh < sh) ? yh : sh;
    dx  = x2 - x1;
    dy  = y2 - y1;
    // draw rectangle: overlap with edges touching, then intersection size
    overlap = (item_r.rect_width != '0) && (item_r.rect_height != '0) &&
              (xw >= cxe) && (xe <= cxw) && (yh >= cye) && (ye <= cyh);
    iw  = ((xw < cxw) ? xw : cxw) - ((xe > cxe) ? xe : cxe);
    ih  = ((yh < cyh) ? yh : cyh) - ((ye > cye) ? ye : cye);
  end

  // sequencer and state update
  always_comb begin
    state_nxt  = state_r;
    surf_w_nxt = surf_w_r;
    surf_h_nxt = surf_h_r;
    clip_x_nxt = clip_x_r;
    clip_y_nxt = clip_y_r;
    clip_w_nxt = clip_w_r;
    clip_h_nxt = clip_h_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    first_nxt  = first_r;
    acc_nxt    = acc_r;
    hsh_nxt    = hsh_r;
    red_nxt    = red_r;
    hbuf_nxt   = hbuf_r;
    hcnt_nxt   = hcnt_r;
    wd_x       = '0;
    wd_y       = '0;
    wd_w       = '0;
    wd_h       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        acc_nxt   = 1'b0;
        hsh_nxt   = 1'b0;
        red_nxt   = 1'b0;
        state_nxt = ST_FIN;
        case (item_r.command)
          fcd_pkg::CMD_BEGIN: begin
            if (item_r.surface_width != surf_w_r ||
                item_r.surface_height != surf_h_r) begin
              first_nxt = 1'b1;
              prev_nxt  = fcd_pkg::FNV_BASIS - 32'd1;
            end
            surf_w_nxt = item_r.surface_width;
            surf_h_nxt = item_r.surface_height;
            cur_nxt    = fcd_pkg::FNV_BASIS;
            clip_x_nxt = '0;
            clip_y_nxt = '0;
            clip_w_nxt = {1'b0, item_r.surface_width};
            clip_h_nxt = {1'b0, item_r.surface_height};
          end
          fcd_pkg::CMD_CLIP: begin
            clip_x_nxt = x1[fcd_pkg::CRD_W-1:0];
            clip_y_nxt = y1[fcd_pkg::CRD_W-1:0];
            clip_w_nxt = (dx > 0) ? dx[15:0] : '0;
            clip_h_nxt = (dy > 0) ? dy[15:0] : '0;
            acc_nxt    = 1'b1;
            wd_x = {{(32-fcd_pkg::SUM_W){x1[fcd_pkg::SUM_W-1]}}, x1};
            wd_y = {{(32-fcd_pkg::SUM_W){y1[fcd_pkg::SUM_W-1]}}, y1};
            wd_w = {16'd0, dx[15:0]};
            wd_h = {16'd0, dy[15:0]};
            if (dx > 0 && dy > 0) begin
              hsh_nxt   = 1'b1;
              hcnt_nxt  = fcd_pkg::HCNT_W'(fcd_pkg::HASH_BYTES_CLIP);
              state_nxt = ST_HASH;
            end
          end
          fcd_pkg::CMD_RECT: begin
            wd_x = {{(32-fcd_pkg::CRD_W){x_r[fcd_pkg::CRD_W-1]}}, x_r};
            wd_y = {{(32-fcd_pkg::CRD_W){y_r[fcd_pkg::CRD_W-1]}}, y_r};
            wd_w = {17'd0, item_r.rect_width};
            wd_h = {17'd0, item_r.rect_height};
            if (overlap) begin
              acc_nxt = 1'b1;
              if (iw > 0 && ih > 0) begin
                hsh_nxt   = 1'b1;
                hcnt_nxt  = fcd_pkg::HCNT_W'(fcd_pkg::HASH_BYTES_RECT);
                state_nxt = ST_HASH;
              end
            end
          end
          default: begin
            // end frame
            if (first_r || cur_r != prev_r) begin
              red_nxt   = 1'b1;
              prev_nxt  = cur_r;
              first_nxt = 1'b0;
            end
          end
        endcase
        // byte packing, first byte in the low lane
        hbuf_nxt = {item_r.color_alpha, item_r.color_blue, item_r.color_green,
                    item_r.color_red, wd_h, wd_w, wd_y, wd_x,
                    {6'd0, item_r.command}};
      end
      ST_HASH: begin
        cur_nxt  = prod;
        hbuf_nxt = hbuf_r >> 8;
        hcnt_nxt = hcnt_r - 1'b1;
        if (hcnt_r == fcd_pkg::HCNT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      surf_w_r    <= '0;
      surf_h_r    <= '0;
      clip_x_r    <= '0;
      clip_y_r    <= '0;
      clip_w_r    <= '0;
      clip_h_r    <= '0;
      cur_r       <= fcd_pkg::FNV_BASIS;
      prev_r      <= fcd_pkg::FNV_BASIS - 32'd1;
      first_r     <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      surf_w_r <= surf_w_nxt;
      surf_h_r <= surf_h_nxt;
      clip_x_r <= clip_x_nxt;
      clip_y_r <= clip_y_nxt;
      clip_w_r <= clip_w_nxt;
      clip_h_r <= clip_h_nxt;
      cur_r    <= cur_nxt;
      prev_r   <= prev_nxt;
      first_r  <= first_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[2])
          fcd_pkg::REG_ORIGIN_X: origin_x_r <= pwdata[15:0];
          fcd_pkg::REG_ORIGIN_Y: origin_y_r <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
      x_r    <= {{2{in_data.rect_x[15]}}, in_data.rect_x} -
                {{2{origin_x_r[15]}}, origin_x_r};
      y_r    <= {{2{in_data.rect_y[15]}}, in_data.rect_y} -
                {{2{origin_y_r[15]}}, origin_y_r};
    end
    acc_r  <= acc_nxt;
    hsh_r  <= hsh_nxt;
    red_r  <= red_nxt;
    hbuf_r <= hbuf_nxt;
    hcnt_r <= hcnt_nxt;
    if (out_load) begin
      out_data_r.accepted   <= acc_r;
      out_data_r.hashed     <= hsh_r;
      out_data_r.redraw     <= red_r;
      out_data_r.frame_hash <= cur_r;
    end
  end

  // checks
  `FCD_ASSERT_NEXT(a_accept_eval, in_fire, state_r == ST_EVAL, "item not evaluated after accept")
  `FCD_ASSERT_IMPL(a_hash_count, state_r == ST_HASH, hcnt_r != '0, "hash step with no bytes left")
  `FCD_ASSERT_IMPL(a_hashed_acc, out_valid_r && out_data_r.hashed, out_data_r.accepted, "hashed item not accepted")
  `FCD_ASSERT_IMPL(a_redraw_only, out_valid_r && out_data_r.redraw, !out_data_r.accepted && !out_data_r.hashed, "redraw on a drawing command")

endmodule

// ===== sim/frame_change_detector_tb.sv =====
`timescale 1ns / 1ps

module frame_change_detector_tb;
  import fcd_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;

  frame_change_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // commands waiting to be sent, results waiting to come back
  in_item_t  cmd_backlog[$];
  out_item_t due_results[$];
  in_item_t  last_frame[$];

  // mirror of the block's state
  int          shift_x    = 0;
  int          shift_y    = 0;
  int          surface_w  = 0;
  int          surface_h  = 0;
  int          win_x      = 0;
  int          win_y      = 0;
  int          win_w      = 0;
  int          win_h      = 0;
  logic [31:0] frame_sum  = FNV_BASIS;
  logic [31:0] shown_sum  = FNV_BASIS - 1;
  logic        new_screen = 1'b1;

  // stimulus and handshake bookkeeping
  int gen_sw       = 640;
  int gen_sh       = 480;
  int in_gap       = 0;
  int out_gap      = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;
  bit item_taken   = 1'b0;

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // FNV-1a helpers
  function automatic logic [31:0] fnv_byte(logic [31:0] h, logic [7:0] b);
    return (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  function automatic logic [31:0] fnv_word(logic [31:0] h, int v);
    logic [31:0] u;
    u = v;
    for (int i = 0; i < 4; i++) h = fnv_byte(h, u[8*i +: 8]);
    return h;
  endfunction

  function automatic logic [31:0] fnv_rect(logic [31:0] h, logic [1:0] code,
                                           int x, int y, int w, int ht);
    h = fnv_byte(h, {6'd0, code});
    h = fnv_word(h, x);
    h = fnv_word(h, y);
    h = fnv_word(h, w);
    return fnv_word(h, ht);
  endfunction

  // apply one command to the mirrored state and work out its result
  function automatic out_item_t apply_command(in_item_t it);
    out_item_t r;
    int x, y, w, h, x1, y1, x2, y2, iw, ih;
    r = '0;
    x = $signed(it.rect_x) - shift_x;
    y = $signed(it.rect_y) - shift_y;
    w = int'(it.rect_width);
    h = int'(it.rect_height);
    case (it.command)
      CMD_BEGIN: begin
        if (int'(it.surface_width) != surface_w || int'(it.surface_height) != surface_h) begin
          surface_w  = int'(it.surface_width);
          surface_h  = int'(it.surface_height);
          new_screen = 1'b1;
          shown_sum  = FNV_BASIS - 1;
        end
        frame_sum = FNV_BASIS;
        win_x = 0;
        win_y = 0;
        win_w = surface_w;
        win_h = surface_h;
      end
      CMD_CLIP: begin
        x1 = (x > 0) ? x : 0;
        y1 = (y > 0) ? y : 0;
        x2 = (x + w < surface_w) ? x + w : surface_w;
        y2 = (y + h < surface_h) ? y + h : surface_h;
        win_x = x1;
        win_y = y1;
        win_w = (x2 - x1 > 0) ? x2 - x1 : 0;
        win_h = (y2 - y1 > 0) ? y2 - y1 : 0;
        r.accepted = 1'b1;
        if (win_w != 0 && win_h != 0) begin
          frame_sum = fnv_rect(frame_sum, CMD_CLIP, win_x, win_y, win_w, win_h);
          r.hashed = 1'b1;
        end
      end
      CMD_RECT: begin
        if (w != 0 && h != 0 && x + w >= win_x && x <= win_x + win_w &&
            y + h >= win_y && y <= win_y + win_h) begin
          iw = ((x + w < win_x + win_w) ? x + w : win_x + win_w) - ((x > win_x) ? x : win_x);
          ih = ((y + h < win_y + win_h) ? y + h : win_y + win_h) - ((y > win_y) ? y : win_y);
          r.accepted = 1'b1;
          // touching edges are kept but leave the hash alone
          if (iw > 0 && ih > 0) begin
            frame_sum = fnv_rect(frame_sum, CMD_RECT, x, y, w, h);
            frame_sum = fnv_byte(frame_sum, it.color_red);
            frame_sum = fnv_byte(frame_sum, it.color_green);
            frame_sum = fnv_byte(frame_sum, it.color_blue);
            frame_sum = fnv_byte(frame_sum, it.color_alpha);
            r.hashed = 1'b1;
          end
        end
      end
      CMD_END: begin
        if (new_screen || frame_sum != shown_sum) begin
          r.redraw   = 1'b1;
          shown_sum  = frame_sum;
          new_screen = 1'b0;
        end
      end
    endcase
    r.frame_hash = frame_sum;
    return r;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // item builders
  function automatic in_item_t mk(logic [1:0] cmd, int x, int y, int w, int h,
                                  logic [31:0] rgba, int sw, int sh);
    in_item_t it;
    it = '0;
    it.command        = cmd;
    it.rect_x         = x[15:0];
    it.rect_y         = y[15:0];
    it.rect_width     = w[14:0];
    it.rect_height    = h[14:0];
    {it.color_red, it.color_green, it.color_blue, it.color_alpha} = rgba;
    it.surface_width  = sw[14:0];
    it.surface_height = sh[14:0];
    return it;
  endfunction

  function automatic in_item_t rnd_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  // raw coordinate that lands at the wanted shifted position, if it fits
  function automatic logic [15:0] place(int shifted, int org);
    int raw;
    raw = shifted + org;
    if (raw < -32768 || raw > 32767) raw = $urandom_range(0, 65535);
    return raw[15:0];
  endfunction

  // position and length along one axis of the surface
  function automatic void pick_span(int extent, output int pos, output int len);
    case ($urandom_range(0, 9))
      0: begin
        len = $urandom_range(0, 32767);
        pos = int'($urandom_range(0, extent + 16)) - 8;
      end
      1: begin
        len = $urandom_range(1, 40);
        pos = -len;
      end
      2: begin
        len = $urandom_range(1, 40);
        pos = extent;
      end
      3: begin
        len = 0;
        pos = int'($urandom_range(0, extent + 16)) - 8;
      end
      default: begin
        len = $urandom_range(1, 64);
        pos = int'($urandom_range(0, extent + 16)) - 8;
      end
    endcase
  endfunction

  function automatic in_item_t body_item(bit is_clip);
    in_item_t it;
    int xs, ys, w, h;
    it = rnd_item();
    it.command = is_clip ? CMD_CLIP : CMD_RECT;
    pick_span(gen_sw, xs, w);
    pick_span(gen_sh, ys, h);
    it.rect_x      = place(xs, shift_x);
    it.rect_y      = place(ys, shift_y);
    it.rect_width  = w[14:0];
    it.rect_height = h[14:0];
    return it;
  endfunction

  function automatic void pick_surface();
    case ($urandom_range(0, 5))
      0: begin gen_sw = 0; gen_sh = 0; end
      1: begin gen_sw = 32767; gen_sh = 32767; end
      2: begin gen_sw = 1; gen_sh = 1; end
      3: begin gen_sw = $urandom_range(0, 32767); gen_sh = $urandom_range(0, 32767); end
      default: begin gen_sw = $urandom_range(1, 800); gen_sh = $urandom_range(1, 600); end
    endcase
  endfunction

  // mostly whole frames, some replayed unchanged, some broken, some noise
  task automatic queue_frames(int count);
    in_item_t frame[$];
    in_item_t it;
    int added;
    added = 0;
    while (added < count) begin
      frame.delete();
      if ($urandom_range(0, 11) == 0) begin
        frame.push_back(rnd_item());
      end else if (last_frame.size() > 0 && $urandom_range(0, 2) == 0) begin
        frame = last_frame;
      end else begin
        if ($urandom_range(0, 7) == 0) pick_surface();
        it = rnd_item();
        it.command        = CMD_BEGIN;
        it.surface_width  = gen_sw[14:0];
        it.surface_height = gen_sh[14:0];
        if ($urandom_range(0, 15) != 0) frame.push_back(it);
        repeat ($urandom_range(0, 6)) frame.push_back(body_item($urandom_range(0, 3) == 0));
        it = rnd_item();
        it.command = CMD_END;
        if ($urandom_range(0, 9) != 0) frame.push_back(it);
        if ($urandom_range(0, 7) == 0) frame.push_back(it);
        last_frame = frame;
      end
      foreach (frame[i]) cmd_backlog.push_back(frame[i]);
      added += frame.size();
    end
  endtask

  // one APB transfer: setup cycle, then access cycle
  task automatic apb_access(bit wr, logic [CFG_ADDR_W-1:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write both origins once the block has drained, then read them back
  task automatic set_origin(int ox, int oy);
    logic [31:0] rd;
    while (cmd_backlog.size() != 0 || due_results.size() != 0 || in_valid) @(posedge clk);
    apb_access(1'b1, {REG_ORIGIN_X, 2'b00}, ox, rd);
    apb_access(1'b1, {REG_ORIGIN_Y, 2'b00}, oy, rd);
    shift_x = ox;
    shift_y = oy;
    apb_access(1'b0, {REG_ORIGIN_X, 2'b00}, '0, rd);
    if (rd[15:0] !== ox[15:0])
      note_mismatch($sformatf("origin_x read %h, wrote %h", rd[15:0], ox[15:0]));
    apb_access(1'b0, {REG_ORIGIN_Y, 2'b00}, '0, rd);
    if (rd[15:0] !== oy[15:0])
      note_mismatch($sformatf("origin_y read %h, wrote %h", rd[15:0], oy[15:0]));
  endtask

  // input driver: present the head of the backlog, with idle bursts between items
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      item_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= cmd_backlog[0];
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 7);
    end
  end

  // monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        due_results.push_back(apply_command(in_data));
        void'(cmd_backlog.pop_front());
        item_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result acc=%b hashed=%b redraw=%b hash=%h",
                                  out_data.accepted, out_data.hashed, out_data.redraw,
                                  out_data.frame_hash));
        end else begin
          want = due_results.pop_front();
          if (out_data !== want)
            note_mismatch($sformatf(
              "expected acc=%b hashed=%b redraw=%b hash=%h, got acc=%b hashed=%b redraw=%b hash=%h",
              want.accepted, want.hashed, want.redraw, want.frame_hash,
              out_data.accepted, out_data.hashed, out_data.redraw, out_data.frame_hash));
        end
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("frame_change_detector_tb: done, errors");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, origins at their reset value
    cmd_backlog.push_back(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0));          // first frame after reset
    cmd_backlog.push_back(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0));          // same sums again
    cmd_backlog.push_back(mk(CMD_RECT, 0, 0, 5, 5, 32'h11223344, 0, 0)); // no frame open yet
    cmd_backlog.push_back(mk(CMD_BEGIN, 0, 0, 0, 0, 0, 640, 480));    // surface size change
    cmd_backlog.push_back(mk(CMD_RECT, 10, 20, 100, 50, 32'hff8000c0, 0, 0));
    cmd_backlog.push_back(mk(CMD_RECT, 10, 20, 0, 50, 32'hff8000c0, 0, 0));   // empty
    cmd_backlog.push_back(mk(CMD_RECT, -10, 30, 10, 10, 32'h01020304, 0, 0)); // touches edge
    cmd_backlog.push_back(mk(CMD_RECT, 700, 30, 10, 10, 32'h01020304, 0, 0)); // misses
    cmd_backlog.push_back(mk(CMD_CLIP, -5, -5, 100, 100, 0, 0, 0));           // cut to surface
    cmd_backlog.push_back(mk(CMD_CLIP, 1000, 10, 20, 20, 0, 0, 0));           // empty clip
    cmd_backlog.push_back(mk(CMD_RECT, 990, 10, 10, 5, 32'h55aa55aa, 0, 0));  // touches it
    cmd_backlog.push_back(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk(CMD_BEGIN, 0, 0, 0, 0, 0, 640, 480));
    cmd_backlog.push_back(mk(CMD_RECT, 10, 20, 100, 50, 32'hff8000c0, 0, 0));
    cmd_backlog.push_back(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0));                  // hash changed
    cmd_backlog.push_back(mk(CMD_BEGIN, 0, 0, 0, 0, 0, 640, 480));
    cmd_backlog.push_back(mk(CMD_RECT, 10, 20, 100, 50, 32'hff8000c0, 0, 0));
    cmd_backlog.push_back(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0));                  // unchanged frame
    cmd_backlog.push_back(mk(CMD_BEGIN, 0, 0, 0, 0, 0, 32767, 32767));
    cmd_backlog.push_back(mk(CMD_RECT, -32768, -32768, 32767, 32767, 32'hffffffff, 0, 0));
    cmd_backlog.push_back(mk(CMD_RECT, 32767, 32767, 32767, 32767, 0, 0, 0));
    cmd_backlog.push_back(mk(CMD_CLIP, -32768, -32768, 32767, 32767, 0, 0, 0));
    cmd_backlog.push_back(mk(CMD_CLIP, 0, 0, 32767, 32767, 0, 0, 0));
    cmd_backlog.push_back(mk(CMD_RECT, -1, -1, 32767, 32767, 32'ha5a5a5a5, 0, 0));
    cmd_backlog.push_back(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0));

    // random phases over a range of origins, extremes included
    set_origin(0, 0);
    queue_frames(500);
    set_origin(-32768, 32767);
    queue_frames(250);
    set_origin(32767, -32768);
    queue_frames(200);
    set_origin($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
    queue_frames(150);
    set_origin($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
    queue_frames(250);

    // last stretch at full rate
    set_origin($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
    calm = 1'b1;
    queue_frames(400);

    while (cmd_backlog.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("frame_change_detector_tb: done, clean");
    end else begin
      $display("frame_change_detector_tb: done, errors");
    end
    $finish;
  end

endmodule
